// File: src/dhalu_pkg.sv
// ----------------------------------------------------------------------------
// dhalu_pkg: shared types and constants of the decimal hundredths ALU
// Request and response structs, operation codes, widths and saturation limits.
// ----------------------------------------------------------------------------
package dhalu_pkg;

  // widths
  localparam int IntBits  = 16;
  localparam int FracBits = 8;
  localparam int OpBits   = 3;
  localparam int MagW     = IntBits + 7;   // magnitude of a scaled operand
  localparam int SgnW     = MagW + 1;      // signed scaled operand
  localparam int DvdW     = MagW + 7;      // scaled dividend, shift register of a cell
  localparam int ProdW    = 2 * MagW;      // full product
  localparam int RemW     = 14;            // remainder of a divide by 100 or 10000
  localparam int FracW    = 7;             // hundredths magnitude

  // operation codes
  localparam logic [OpBits-1:0] OpAdd = OpBits'(0);
  localparam logic [OpBits-1:0] OpSub = OpBits'(1);
  localparam logic [OpBits-1:0] OpMul = OpBits'(2);
  localparam logic [OpBits-1:0] OpDiv = OpBits'(3);
  localparam logic [OpBits-1:0] OpCmp = OpBits'(4);

  // scaled saturation limits
  localparam longint PosLimL = ((64'sd1 <<< (IntBits - 1)) - 64'sd1) * 64'sd100 + 64'sd99;
  localparam longint NegLimL = (64'sd1 <<< (IntBits - 1)) * 64'sd100 + 64'sd99;
  localparam logic [MagW-1:0]  PosLim   = MagW'(PosLimL);
  localparam logic [MagW-1:0]  NegLim   = MagW'(NegLimL);
  localparam logic [ProdW-1:0] PosLimP  = ProdW'(PosLimL * 64'sd100 + 64'sd99);
  localparam logic [ProdW-1:0] NegLimP  = ProdW'(NegLimL * 64'sd100 + 64'sd99);
  localparam logic [DvdW-1:0]  PosLimX  = DvdW'(PosLimL * 64'sd100);
  localparam logic [DvdW-1:0]  NegLimX  = DvdW'(NegLimL * 64'sd100);

  // divisors of the split chain and reciprocal for hundredths of a remainder
  localparam logic [RemW:0] Div100  = (RemW + 1)'(100);
  localparam logic [RemW:0] Div10k  = (RemW + 1)'(10000);
  localparam int            RecipW  = 13;
  localparam logic [RecipW-1:0] Recip100 = RecipW'(5243);
  localparam int            RecipSh = 19;

  typedef struct packed {
    logic [OpBits-1:0]          operation;
    logic signed [IntBits-1:0]  a_int;
    logic signed [FracBits-1:0] a_frac;
    logic signed [IntBits-1:0]  b_int;
    logic signed [FracBits-1:0] b_frac;
  } alu_req_t;

  typedef struct packed {
    logic signed [IntBits-1:0]  r_int;
    logic signed [FracBits-1:0] r_frac;
    logic                       greater;
    logic                       less;
    logic                       equal;
    logic                       overflow;
    logic                       div_by_zero;
  } alu_rsp_t;

  // side data carried along the multiply/divide chain
  typedef struct packed {
    logic [OpBits-1:0] op;
    logic              neg;
    logic              gt;
    logic              lt;
    logic              eq;
    logic              dbz;
    logic [MagW:0]     as_mag;
  } side_t;

  typedef struct packed {
    logic             valid;
    logic             is_div;
    logic [ProdW-1:0] acc;
    logic [DvdW-1:0]  shf;
    logic [MagW-1:0]  dvs;
    side_t            side;
  } md_t;

  typedef struct packed {
    logic            valid;
    logic            wide;
    logic [RemW-1:0] rem;
    logic [DvdW-1:0] shf;
    logic            neg;
    logic            sat;
    logic            gt;
    logic            lt;
    logic            eq;
    logic            dbz;
  } sc_t;

endpackage

// File: src/dhalu_front.sv
// ----------------------------------------------------------------------------
// dhalu_front: operand scaling stage
// Forms the scaled operands, add/subtract magnitude, compare flags and the
// start values of the multiply/divide chain.
// ----------------------------------------------------------------------------
module dhalu_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  dhalu_pkg::alu_req_t req_i,
  output dhalu_pkg::md_t      md_o
);
  import dhalu_pkg::*;

  logic [SgnW-1:0] sa, sb;
  logic [MagW-1:0] ma, mb;
  logic [SgnW:0]   v;
  logic [SgnW:0]   v_mag;
  logic            sa_neg, sb_neg;
  md_t             md_d, md_q;

  // scaled operands, int * 100 + frac
  assign sa = SgnW'(req_i.a_int) * SgnW'(100) + SgnW'(req_i.a_frac);
  assign sb = SgnW'(req_i.b_int) * SgnW'(100) + SgnW'(req_i.b_frac);
  assign sa_neg = sa[SgnW-1];
  assign sb_neg = sb[SgnW-1];
  assign ma = sa_neg ? MagW'(-sa) : MagW'(sa);
  assign mb = sb_neg ? MagW'(-sb) : MagW'(sb);

  // add or subtract in full width
  assign v = (req_i.operation == OpSub) ? ({sa[SgnW-1], sa} - {sb[SgnW-1], sb})
                                        : ({sa[SgnW-1], sa} + {sb[SgnW-1], sb});
  assign v_mag = v[SgnW] ? -v : v;

  always_comb begin
    md_d             = '0;
    md_d.valid       = valid_i;
    md_d.is_div      = (req_i.operation == OpDiv);
    md_d.side.op     = req_i.operation;
    md_d.side.as_mag = v_mag[MagW:0];
    if (req_i.operation == OpAdd || req_i.operation == OpSub) begin
      md_d.side.neg = v[SgnW];
    end else begin
      md_d.side.neg = sa_neg ^ sb_neg;
    end
    md_d.side.gt  = (req_i.operation == OpCmp) && ($signed(sa) > $signed(sb));
    md_d.side.lt  = (req_i.operation == OpCmp) && ($signed(sa) < $signed(sb));
    md_d.side.eq  = (req_i.operation == OpCmp) && (sa == sb);
    md_d.side.dbz = (req_i.operation == OpDiv) && (mb == '0);
    // chain start: multiplier bits or scaled dividend
    if (req_i.operation == OpDiv) begin
      md_d.shf = DvdW'(ma) * DvdW'(100);
      md_d.dvs = mb;
    end else begin
      md_d.shf = DvdW'(mb);
      md_d.dvs = ma;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q <= '0;
    end else if (en_i) begin
      md_q <= md_d;
    end
  end

  assign md_o = md_q;

endmodule

// File: src/dhalu_md_cell.sv
// ----------------------------------------------------------------------------
// dhalu_md_cell: one bit of the shared multiply/divide chain
// Multiply: shift-and-add of one multiplier bit. Divide: one restoring step.
// ----------------------------------------------------------------------------
module dhalu_md_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  dhalu_pkg::md_t md_i,
  output dhalu_pkg::md_t md_o
);
  import dhalu_pkg::*;

  logic             top_bit;
  logic [DvdW-1:0]  shl;
  logic [ProdW-1:0] r;
  logic [ProdW-1:0] dvs_w;
  md_t              md_d, md_q;

  assign top_bit = md_i.shf[DvdW-1];
  assign shl     = {md_i.shf[DvdW-2:0], 1'b0};
  assign dvs_w   = ProdW'(md_i.dvs);
  assign r       = {md_i.acc[ProdW-2:0], top_bit};

  always_comb begin
    md_d = md_i;
    if (md_i.is_div) begin
      // restoring step, quotient bit enters from the right
      if (r >= dvs_w) begin
        md_d.acc = r - dvs_w;
        md_d.shf = shl | DvdW'(1);
      end else begin
        md_d.acc = r;
        md_d.shf = shl;
      end
    end else begin
      // msb-first shift and add
      md_d.acc = {md_i.acc[ProdW-2:0], 1'b0} + (top_bit ? dvs_w : '0);
      md_d.shf = shl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q <= '0;
    end else if (en_i) begin
      md_q <= md_d;
    end
  end

  assign md_o = md_q;

endmodule

// File: src/dhalu_sc_cell.sv
// ----------------------------------------------------------------------------
// dhalu_sc_cell: one bit of the split chain
// Restoring step of a divide by 100, or by 10000 for a product.
// ----------------------------------------------------------------------------
module dhalu_sc_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  dhalu_pkg::sc_t sc_i,
  output dhalu_pkg::sc_t sc_o
);
  import dhalu_pkg::*;

  logic [RemW:0]   r;
  logic [RemW:0]   dv;
  logic [DvdW-1:0] shl;
  sc_t             sc_d, sc_q;

  assign r   = {sc_i.rem, sc_i.shf[DvdW-1]};
  assign dv  = sc_i.wide ? Div10k : Div100;
  assign shl = {sc_i.shf[DvdW-2:0], 1'b0};

  always_comb begin
    sc_d = sc_i;
    if (r >= dv) begin
      sc_d.rem = RemW'(r - dv);
      sc_d.shf = shl | DvdW'(1);
    end else begin
      sc_d.rem = RemW'(r);
      sc_d.shf = shl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= '0;
    end else if (en_i) begin
      sc_q <= sc_d;
    end
  end

  assign sc_o = sc_q;

endmodule

// File: src/decimal_hundredths_alu.sv
// ----------------------------------------------------------------------------
// decimal_hundredths_alu: decimal ALU with two fraction digits
// Add, subtract, multiply, divide and compare on int*100+frac scaled values,
// with saturation, overflow and divide-by-zero flags.
// ----------------------------------------------------------------------------
//  channel | handshake                  | payload
//  --------+----------------------------+--------------------------
//  in      | in_valid_i / in_ready_o    | in_req_i   (alu_req_t)
//  out     | out_valid_o / out_ready_i  | out_rsp_o  (alu_rsp_t)
//
// one request enters per cycle unless stalled; a request passes the front register,
// the multiply/divide chain, the split register, the split chain (each chain one cell per bit) and the output register.
// reset clears all valid bits; no clearing pass.
// a result held at the output stalls the whole pipeline; in_ready_o follows it.
// ----------------------------------------------------------------------------
module decimal_hundredths_alu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dhalu_pkg::alu_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output dhalu_pkg::alu_rsp_t out_rsp_o
);
  import dhalu_pkg::*;

  logic     en;
  md_t      md_chain [DvdW+1];
  sc_t      sc_chain [DvdW+1];
  sc_t      sc_d, sc_q;
  logic     out_valid_q;
  alu_rsp_t out_q, out_d;

  // global advance
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  dhalu_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .req_i   (in_req_i),
    .md_o    (md_chain[0])
  );

  // multiply/divide chain
  for (genvar i = 0; i < DvdW; i++) begin : g_md
    dhalu_md_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .md_i   (md_chain[i]),
      .md_o   (md_chain[i+1])
    );
  end

  // saturation and split setup
  always_comb begin
    md_t             m;
    logic [MagW-1:0] lim;
    logic [ProdW-1:0] limp;
    logic [DvdW-1:0] limx;
    m        = md_chain[DvdW];
    lim      = m.side.neg ? NegLim : PosLim;
    limp     = m.side.neg ? NegLimP : PosLimP;
    limx     = m.side.neg ? NegLimX : PosLimX;
    sc_d       = '0;
    sc_d.valid = m.valid;
    sc_d.neg   = m.side.neg;
    sc_d.gt    = m.side.gt;
    sc_d.lt    = m.side.lt;
    sc_d.eq    = m.side.eq;
    sc_d.dbz   = m.side.dbz;
    case (m.side.op)
      OpAdd, OpSub: begin
        if (m.side.as_mag > (MagW + 1)'(lim)) begin
          sc_d.sat = 1'b1;
          sc_d.shf = DvdW'(lim);
        end else begin
          sc_d.shf = DvdW'(m.side.as_mag);
        end
      end
      OpMul: begin
        sc_d.wide = 1'b1;
        if (m.acc > limp) begin
          sc_d.sat = 1'b1;
          sc_d.shf = limx;
        end else begin
          sc_d.shf = m.acc[DvdW-1:0];
        end
      end
      OpDiv: begin
        if (m.side.dbz) begin
          sc_d.shf = '0;
        end else if (m.shf > DvdW'(lim)) begin
          sc_d.sat = 1'b1;
          sc_d.shf = DvdW'(lim);
        end else begin
          sc_d.shf = m.shf;
        end
      end
      default: begin
        sc_d.shf = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= '0;
    end else if (en) begin
      sc_q <= sc_d;
    end
  end

  assign sc_chain[0] = sc_q;

  // split chain
  for (genvar j = 0; j < DvdW; j++) begin : g_sc
    dhalu_sc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .sc_i   (sc_chain[j]),
      .sc_o   (sc_chain[j+1])
    );
  end

  // sign and hundredths of the result
  always_comb begin
    sc_t                      s;
    logic [IntBits-1:0]       ip;
    logic [RemW+RecipW-1:0]   rp;
    logic [FracW-1:0]         fp;
    s  = sc_chain[DvdW];
    ip = s.shf[IntBits-1:0];
    rp = (RemW + RecipW)'(s.rem) * (RemW + RecipW)'(Recip100);
    fp = s.wide ? rp[RecipSh +: FracW] : s.rem[FracW-1:0];
    out_d             = '0;
    out_d.r_int       = s.neg ? -ip : ip;
    out_d.r_frac      = s.neg ? -FracBits'(fp) : FracBits'(fp);
    out_d.greater     = s.gt;
    out_d.less        = s.lt;
    out_d.equal       = s.eq;
    out_d.overflow    = s.sat;
    out_d.div_by_zero = s.dbz;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sc_chain[DvdW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// File: tb/tb_decimal_hundredths_alu.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_decimal_hundredths_alu: self-checking bench of the decimal hundredths ALU
// Directed corner requests then bursty random traffic with a stalling sink;
// each response is checked field by field against an in-bench prediction.
// ----------------------------------------------------------------------------
module tb_decimal_hundredths_alu;
  import dhalu_pkg::*;

  localparam int Latency  = 63;
  localparam int StallMax = 2000;

  // operation codes outside the defined set
  localparam logic [OpBits-1:0] OpSpareLo = OpBits'(5);
  localparam logic [OpBits-1:0] OpSpareHi = OpBits'(7);

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  alu_req_t in_req_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  alu_rsp_t out_rsp_o;

  alu_rsp_t expected_rsp_q[$];
  int       error_cnt = 0;
  int       idle_cycles = 0;
  bit       sink_free_run = 1'b0;

  decimal_hundredths_alu dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_req_i,
    .out_valid_o, .out_ready_i, .out_rsp_o
  );

  always #5 clk_i = ~clk_i;

  // split a scaled magnitude into parts with saturation
  function automatic void split_scaled(bit neg, logic [127:0] mag, bit too_big,
                                       ref alu_rsp_t r);
    logic [127:0] lim;
    logic [127:0] ip;
    logic [127:0] fp;
    lim = neg ? 128'(NegLimL) : 128'(PosLimL);
    if (too_big || mag > lim) begin
      mag = lim;
      r.overflow = 1'b1;
    end
    ip = mag / 100;
    fp = mag % 100;
    if (neg) begin
      ip = -ip;
      fp = -fp;
    end
    r.r_int  = ip[IntBits-1:0];
    r.r_frac = fp[FracBits-1:0];
  endfunction

  // expected response of one request
  function automatic alu_rsp_t predict_alu(alu_req_t q);
    alu_rsp_t r;
    longint sa, sb, s;
    logic [127:0] ma, mb, qt;
    bit neg;
    r = '0;
    sa = longint'(q.a_int) * 100 + longint'(q.a_frac);
    sb = longint'(q.b_int) * 100 + longint'(q.b_frac);
    ma = (sa < 0) ? 128'(-sa) : 128'(sa);
    mb = (sb < 0) ? 128'(-sb) : 128'(sb);
    neg = (sa < 0) != (sb < 0);
    case (q.operation)
      OpAdd, OpSub: begin
        s = (q.operation == OpAdd) ? sa + sb : sa - sb;
        split_scaled(s < 0, (s < 0) ? 128'(-s) : 128'(s), 1'b0, r);
      end
      OpMul: split_scaled(neg && ma != 0 && mb != 0, (ma * mb) / 100, 1'b0, r);
      OpDiv: begin
        if (mb == 0) r.div_by_zero = 1'b1;
        else begin
          qt = (ma * 100) / mb;
          split_scaled(neg && qt != 0, qt, 1'b0, r);
        end
      end
      OpCmp: begin
        r.greater = sa > sb;
        r.less    = sa < sb;
        r.equal   = sa == sb;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_cnt++;
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // response checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsp_q.size() == 0) report_mismatch("unexpected response", 1, 0);
      else begin
        alu_rsp_t e;
        e = expected_rsp_q.pop_front();
        if (out_rsp_o.r_int !== e.r_int) report_mismatch("r_int", out_rsp_o.r_int, e.r_int);
        if (out_rsp_o.r_frac !== e.r_frac)
          report_mismatch("r_frac", out_rsp_o.r_frac, e.r_frac);
        if (out_rsp_o.greater !== e.greater)
          report_mismatch("greater", out_rsp_o.greater, e.greater);
        if (out_rsp_o.less !== e.less) report_mismatch("less", out_rsp_o.less, e.less);
        if (out_rsp_o.equal !== e.equal) report_mismatch("equal", out_rsp_o.equal, e.equal);
        if (out_rsp_o.overflow !== e.overflow)
          report_mismatch("overflow", out_rsp_o.overflow, e.overflow);
        if (out_rsp_o.div_by_zero !== e.div_by_zero)
          report_mismatch("div_by_zero", out_rsp_o.div_by_zero, e.div_by_zero);
      end
    end
  end

  // sink stall pattern: alternating free and choppy phases
  always @(negedge clk_i) begin
    if (sink_free_run || ($urandom_range(0, 199) == 0)) sink_free_run <= ($urandom_range(0, 9) != 0);
    if (sink_free_run) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 3) == 0);
  end

  // watchdog on cycles with no accepted request or response
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallMax) begin
      $display("Verification failed");
      $finish;
    end
  end

  // send one request, holding valid until accepted
  task automatic send_request(alu_req_t q);
    in_req_i   <= q;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_rsp_q.push_back(predict_alu(q));
    @(negedge clk_i);
  endtask

  task automatic idle_source(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  function automatic alu_req_t make_req(logic [OpBits-1:0] op, int ai, int af, int bi, int bf);
    alu_req_t q;
    q.operation = op;
    q.a_int = IntBits'(ai);
    q.a_frac = FracBits'(af);
    q.b_int = IntBits'(bi);
    q.b_frac = FracBits'(bf);
    return q;
  endfunction

  function automatic alu_req_t random_req();
    alu_req_t q;
    int mode;
    q = make_req(OpBits'($urandom_range(0, 4)), 0, 0, 0, 0);
    if ($urandom_range(0, 19) == 0) q.operation = OpBits'($urandom_range(0, 7));
    mode = $urandom_range(0, 9);
    q.a_int = (mode < 3) ? IntBits'(int'($urandom_range(0, 40)) - 20) : IntBits'($urandom);
    q.b_int = (mode < 5) ? IntBits'(int'($urandom_range(0, 40)) - 20) : IntBits'($urandom);
    if (mode == 9) begin
      // raw fraction bits, out of range and mixed sign included
      q.a_frac = FracBits'($urandom);
      q.b_frac = FracBits'($urandom);
    end else begin
      q.a_frac = FracBits'(int'($urandom_range(0, 198)) - 99);
      q.b_frac = FracBits'(int'($urandom_range(0, 198)) - 99);
    end
    if ($urandom_range(0, 29) == 0) begin
      q.b_int = '0;
      q.b_frac = '0;
    end
    if ($urandom_range(0, 19) == 0) begin
      q.b_int = q.a_int;
      q.b_frac = q.a_frac;
    end
    return q;
  endfunction

  // extremes, every operation, saturation, divide by zero, odd fractions
  task automatic test_directed();
    send_request(make_req(OpAdd, 32767, 99, 32767, 99));
    send_request(make_req(OpAdd, -32768, -99, -32768, -99));
    send_request(make_req(OpAdd, 32767, 99, 0, 0));
    send_request(make_req(OpSub, 1, 50, 1, 51));
    send_request(make_req(OpSub, -32768, -99, 32767, 99));
    send_request(make_req(OpSub, 32767, 99, -32768, -99));
    send_request(make_req(OpMul, 32767, 99, 32767, 99));
    send_request(make_req(OpMul, -32768, -99, 32767, 99));
    send_request(make_req(OpMul, 0, -1, 0, 50));
    send_request(make_req(OpMul, 0, 0, -5, -5));
    send_request(make_req(OpMul, 1, 1, -1, -1));
    send_request(make_req(OpDiv, 5, 0, 0, 0));
    send_request(make_req(OpDiv, 32767, 99, 0, 1));
    send_request(make_req(OpDiv, -32768, -99, 0, 1));
    send_request(make_req(OpDiv, 0, 1, -3, 0));
    send_request(make_req(OpDiv, -10, 0, 3, 0));
    send_request(make_req(OpCmp, 1, 0, 0, 100));
    send_request(make_req(OpCmp, -1, 0, 0, 0));
    send_request(make_req(OpCmp, 32767, 99, -32768, -99));
    send_request(make_req(OpAdd, 0, -128, 0, 127));
    send_request(make_req(OpSub, 1, -50, -1, 50));
    send_request(make_req(OpSpareLo, 12, 34, 56, 78));
    send_request(make_req(OpSpareHi, -1, -1, -1, -1));
  endtask

  // bursty random traffic, with one full drain along the way
  task automatic test_random(int n);
    int sent;
    int burst;
    bit drained;
    sent = 0;
    drained = 1'b0;
    while (sent < n) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && sent < n) begin
        send_request(random_req());
        sent++;
        burst--;
      end
      if (!drained && sent >= n / 2) begin
        drained = 1'b1;
        idle_source(1);
        while (expected_rsp_q.size() != 0) @(negedge clk_i);
      end else if ($urandom_range(0, 2) != 0) idle_source($urandom_range(1, 12));
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(1400);
    while (expected_rsp_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 10) @(negedge clk_i);
    if (error_cnt == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// File: filelist.f
src/dhalu_pkg.sv
src/dhalu_front.sv
src/dhalu_md_cell.sv
src/dhalu_sc_cell.sv
src/decimal_hundredths_alu.sv
tb/tb_decimal_hundredths_alu.sv
